@@ rtl/gcpa_pkg.sv @@
// gcpa_pkg: shared constants, types and the opcode length table of the
// command packet assembler. No dependencies.
`timescale 1ns / 1ps

package gcpa_pkg;

   // largest packet the assembler will hold; longer table entries saturate
   localparam int MAX_PACKET_WORDS = 16;
   localparam int LEN_W            = $clog2(MAX_PACKET_WORDS + 1);
   localparam int RAW_LEN_W        = 5;

   // opcodes with special meaning
   localparam logic [7:0] OP_DRAW_MODE = 8'hE1;

   // command classes
   localparam logic [3:0] CLS_NOP       = 4'd0;
   localparam logic [3:0] CLS_ATTRIBUTE = 4'd1;
   localparam logic [3:0] CLS_FILL      = 4'd2;
   localparam logic [3:0] CLS_POLYGON   = 4'd3;
   localparam logic [3:0] CLS_LINE      = 4'd4;
   localparam logic [3:0] CLS_RECT      = 4'd5;
   localparam logic [3:0] CLS_VRAM_VRAM = 4'd6;
   localparam logic [3:0] CLS_CPU_VRAM  = 4'd7;
   localparam logic [3:0] CLS_VRAM_CPU  = 4'd8;

   // decoded view of one opcode
   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [3:0]       cls;
      logic             unknown;
   } op_info_type;

   // raw packet length in words for each opcode
   function automatic logic [RAW_LEN_W-1:0] packet_length(input logic [7:0] op);
      logic [RAW_LEN_W-1:0] len;
      case (op) inside
         8'h02:                                  len = 5'd3;
         [8'h20:8'h23]:                          len = 5'd4;
         [8'h24:8'h27]:                          len = 5'd7;
         [8'h28:8'h2B]:                          len = 5'd5;
         [8'h2C:8'h2F], [8'h34:8'h37]:           len = 5'd9;
         [8'h30:8'h33]:                          len = 5'd6;
         [8'h38:8'h3B]:                          len = 5'd8;
         [8'h3C:8'h3F]:                          len = 5'd12;
         [8'h40:8'h47]:                          len = 5'd3;
         [8'h48:8'h4F], [8'h58:8'h5F]:           len = 5'd16;
         [8'h50:8'h57]:                          len = 5'd4;
         [8'h60:8'h62]:                          len = 5'd3;
         [8'h64:8'h67]:                          len = 5'd4;
         8'h68, 8'h6A, 8'h70, 8'h72, 8'h78, 8'h7A, 8'h7B: len = 5'd2;
         [8'h6C:8'h6F], [8'h74:8'h77], [8'h7C:8'h7F]:   len = 5'd3;
         [8'h80:8'h9F]:                          len = 5'd4;
         [8'hA0:8'hDF]:                          len = 5'd3;
         default:                                len = 5'd1;
      endcase
      return len;
   endfunction

endpackage

@@ rtl/gcpa_decode.sv @@
// gcpa_decode: opcode decode, giving packet length (saturated), command
// class and the unsupported-opcode flag. Depends on gcpa_pkg.
`timescale 1ns / 1ps

module gcpa_decode
   import gcpa_pkg::*;
(
   input  logic [7:0]  opcode,
   output op_info_type info
);

   logic [RAW_LEN_W-1:0] raw_len;

   // table length clipped to the largest packet held, then command class
   always_comb begin
      raw_len = packet_length(opcode);
      if (32'(raw_len) > MAX_PACKET_WORDS) begin
         info.len = LEN_W'(MAX_PACKET_WORDS);
      end else begin
         info.len = LEN_W'(raw_len);
      end

      info.unknown = 1'b0;
      case (opcode) inside
         8'h00:         info.cls = CLS_NOP;
         8'h01:         info.cls = CLS_ATTRIBUTE;
         8'h02:         info.cls = CLS_FILL;
         [8'h20:8'h3F]: info.cls = CLS_POLYGON;
         [8'h40:8'h5F]: info.cls = CLS_LINE;
         [8'h60:8'h7F]: info.cls = CLS_RECT;
         [8'h80:8'h9F]: info.cls = CLS_VRAM_VRAM;
         [8'hA0:8'hBF]: info.cls = CLS_CPU_VRAM;
         [8'hC0:8'hDF]: info.cls = CLS_VRAM_CPU;
         [8'hE1:8'hE6]: info.cls = CLS_ATTRIBUTE;
         default: begin
            info.cls     = CLS_NOP;
            info.unknown = 1'b1;
         end
      endcase
   end

endmodule

@@ rtl/gpu_command_packet_assembler_top.sv @@
// gpu_command_packet_assembler_top: packet state registers, step logic and
// result register. Depends on gcpa_pkg and gcpa_decode.
`timescale 1ns / 1ps

// Takes one 32-bit command word per item and returns one result item per
// word. The top byte of the first word of a packet is its opcode; the
// packet closes after the table length for that opcode, at which point the
// class and unsupported flag are reported and the held count returns to
// zero. A closing draw-mode packet (opcode E1) loads bits 13..0 of its word
// into the draw mode. Throughput is one item per clock unless stalled: the
// step is a table lookup, one increment and compare, and a decode between
// the packet state registers and the result register, so each result
// appears the cycle after its word is accepted. The input stays ready
// while the result register is empty or being drained in the same cycle.
module gpu_command_packet_assembler_top
   import gcpa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_command_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_packet_done,
   output logic [3:0]  rsp_command_class,
   output logic        rsp_unknown_opcode,
   output logic [3:0]  rsp_words_held,
   output logic [13:0] rsp_draw_mode
);

   logic [7:0]       opcode_ff, opcode_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic [13:0]      draw_mode_ff, draw_mode_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             done_ff;
   logic [3:0]       class_ff;
   logic             unknown_ff;
   logic [3:0]       held_ff;
   logic [13:0]      mode_ff;

   logic             accept;
   logic [LEN_W-1:0] count_inc;
   logic             done;
   op_info_type      info;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // opcode of the packet in flight, taken from the first word
   assign opcode_in = (count_ff == '0) ? req_command_word[31:24] : opcode_ff;

   gcpa_decode u_decode (
      .opcode (opcode_in),
      .info   (info)
   );

   // count words and close the packet at its length
   always_comb begin
      count_inc    = count_ff + LEN_W'(1);
      done         = (count_inc >= info.len);
      count_in     = done ? '0 : count_inc;
      draw_mode_in = (done && opcode_in == OP_DRAW_MODE) ?
                     req_command_word[13:0] : draw_mode_ff;
   end

   // packet state
   always_ff @(posedge clock) begin
      if (reset) begin
         opcode_ff    <= '0;
         count_ff     <= '0;
         draw_mode_ff <= '0;
      end else if (accept) begin
         opcode_ff    <= opcode_in;
         count_ff     <= count_in;
         draw_mode_ff <= draw_mode_in;
      end
   end

   // result register valid
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded with each accepted item
   always_ff @(posedge clock) begin
      if (accept) begin
         done_ff    <= done;
         class_ff   <= done ? info.cls : CLS_NOP;
         unknown_ff <= done && info.unknown;
         held_ff    <= 4'(count_in);
         mode_ff    <= draw_mode_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_packet_done    = done_ff;
   assign rsp_command_class  = class_ff;
   assign rsp_unknown_opcode = unknown_ff;
   assign rsp_words_held     = held_ff;
   assign rsp_draw_mode      = mode_ff;

endmodule

@@ rtl/gcpa_checker.sv @@
// gcpa_checker: port-level assertions for the command packet assembler,
// bound to gpu_command_packet_assembler_top. Depends on gcpa_pkg.
`timescale 1ns / 1ps

module gcpa_checker
   import gcpa_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_packet_done,
   input logic [3:0]  rsp_command_class,
   input logic        rsp_unknown_opcode,
   input logic [3:0]  rsp_words_held,
   input logic [13:0] rsp_draw_mode
);

   // a stalled result item holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_packet_done) &&
      $stable(rsp_command_class) && $stable(rsp_words_held) &&
      $stable(rsp_draw_mode))
      else $error("result item changed while stalled");

   // a new result item only follows an accepted input item
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result item without an input item");

   // open packets report no class and no unsupported flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_packet_done |->
      rsp_command_class == CLS_NOP && !rsp_unknown_opcode)
      else $error("class reported for an open packet");

   // a closed packet leaves nothing held; unsupported opcodes carry no class
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_done |-> rsp_words_held == 4'd0 &&
      (!rsp_unknown_opcode || rsp_command_class == CLS_NOP))
      else $error("closed packet left words held or bad class");

   // the held count stays below the largest packet size
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_words_held) < MAX_PACKET_WORDS)
      else $error("held count beyond packet limit");

endmodule

bind gpu_command_packet_assembler_top gcpa_checker u_gcpa_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_packet_done    (rsp_packet_done),
   .rsp_command_class  (rsp_command_class),
   .rsp_unknown_opcode (rsp_unknown_opcode),
   .rsp_words_held     (rsp_words_held),
   .rsp_draw_mode      (rsp_draw_mode)
);

@@ test/packet_result_checker.sv @@
// packet_result_checker: watches both item channels of the command packet
// assembler, predicts each result from the accepted command words and compares.
// Depends on gcpa_pkg for the class codes, the draw-mode opcode and the size limit.
`timescale 1ns / 1ps

module packet_result_checker
   import gcpa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_command_word,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_packet_done,
   input  logic [3:0]  rsp_command_class,
   input  logic        rsp_unknown_opcode,
   input  logic [3:0]  rsp_words_held,
   input  logic [13:0] rsp_draw_mode,
   output int          mismatch_count,
   output int          results_owed
);

   // one result item as the block should report it
   typedef struct packed {
      logic        done;
      logic [3:0]  cls;
      logic        unk;
      logic [3:0]  held;
      logic [13:0] mode;
   } step_result_type;

   // polygon packet sizes, four opcodes per entry, entry 0 in the low nibble
   localparam logic [31:0] POLYGON_LENS = {4'd12, 4'd8, 4'd9, 4'd6, 4'd9, 4'd5, 4'd7, 4'd4};

   // predicted packet state
   logic [7:0]      open_opcode   = '0;
   logic [4:0]      words_in      = '0;
   logic [13:0]     draw_mode_now = '0;
   step_result_type results_due[$];

   // advance the packet state by one command word and return its result
   function automatic step_result_type assemble_word(input logic [31:0] word);
      step_result_type r    = '0;
      logic [4:0]      need = 5'd1;
      if (words_in == 5'd0) begin
         open_opcode = word[31:24];
      end
      words_in = words_in + 5'd1;

      // words in a full packet for the open opcode
      case (open_opcode) inside
         8'h02:                                        need = 5'd3;
         [8'h20:8'h3F]:  need = 5'(POLYGON_LENS[open_opcode[4:2] * 4 +: 4]);
         [8'h40:8'h5F]:  need = open_opcode[3] ? 5'd16 : (open_opcode[4] ? 5'd4 : 5'd3);
         8'h63, 8'h69, 8'h6B, 8'h71, 8'h73, 8'h79:     need = 5'd1;
         8'h68, 8'h6A, 8'h70, 8'h72, 8'h78, 8'h7A, 8'h7B: need = 5'd2;
         [8'h64:8'h67]:                                need = 5'd4;
         [8'h60:8'h7F]:                                need = 5'd3;
         [8'h80:8'h9F]:                                need = 5'd4;
         [8'hA0:8'hDF]:                                need = 5'd3;
         default:                                      need = 5'd1;
      endcase
      if (need > MAX_PACKET_WORDS) begin
         need = 5'(MAX_PACKET_WORDS);
      end

      // packet complete: decode the class and close it
      if (words_in >= need) begin
         r.done = 1'b1;
         case (open_opcode) inside
            8'h00:          r.cls = CLS_NOP;
            8'h01:          r.cls = CLS_ATTRIBUTE;
            8'h02:          r.cls = CLS_FILL;
            [8'h20:8'h3F]:  r.cls = CLS_POLYGON;
            [8'h40:8'h5F]:  r.cls = CLS_LINE;
            [8'h60:8'h7F]:  r.cls = CLS_RECT;
            [8'h80:8'h9F]:  r.cls = CLS_VRAM_VRAM;
            [8'hA0:8'hBF]:  r.cls = CLS_CPU_VRAM;
            [8'hC0:8'hDF]:  r.cls = CLS_VRAM_CPU;
            [8'hE1:8'hE6]:  r.cls = CLS_ATTRIBUTE;
            default: begin
               r.cls = CLS_NOP;
               r.unk = 1'b1;
            end
         endcase
         if (open_opcode == OP_DRAW_MODE) begin
            draw_mode_now = word[13:0];
         end
         words_in = 5'd0;
      end
      r.held = words_in[3:0];
      r.mode = draw_mode_now;
      return r;
   endfunction

   // report one field that differs from its prediction
   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // result side first: its item was accepted on an earlier edge
   always @(posedge clock) begin
      step_result_type due;
      if (reset) begin
         open_opcode    = '0;
         words_in       = '0;
         draw_mode_now  = '0;
         mismatch_count = 0;
         results_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               $display("%0t: result item with none expected, done %0b class %0d held %0d",
                        $time, rsp_packet_done, rsp_command_class, rsp_words_held);
               mismatch_count++;
            end else begin
               due = results_due.pop_front();
               check_field("packet_done", 32'(due.done), 32'(rsp_packet_done));
               check_field("command_class", 32'(due.cls), 32'(rsp_command_class));
               check_field("unknown_opcode", 32'(due.unk), 32'(rsp_unknown_opcode));
               check_field("words_held", 32'(due.held), 32'(rsp_words_held));
               check_field("draw_mode", 32'(due.mode), 32'(rsp_draw_mode));
            end
         end
         if (req_valid && req_ready) begin
            results_due = {results_due, assemble_word(req_command_word)};
         end
      end
      results_owed = results_due.size();
   end

endmodule

@@ test/gpu_command_packet_assembler_top_tb.sv @@
// gpu_command_packet_assembler_top_tb: clock, reset and command word stimulus
// for the packet assembler, with random idling on both channels.
// Depends on gcpa_pkg, gpu_command_packet_assembler_top and packet_result_checker.
`timescale 1ns / 1ps

module gpu_command_packet_assembler_top_tb
   import gcpa_pkg::*;
();

   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASE_WORDS  = 230;
   localparam int DRAIN_CYCLES = 4;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [31:0] req_command_word = '0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic        rsp_packet_done;
   logic [3:0]  rsp_command_class;
   logic        rsp_unknown_opcode;
   logic [3:0]  rsp_words_held;
   logic [13:0] rsp_draw_mode;

   int mismatch_count;
   int results_owed;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int quiet_cycles  = 0;

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   gpu_command_packet_assembler_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command_word   (req_command_word),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_packet_done    (rsp_packet_done),
      .rsp_command_class  (rsp_command_class),
      .rsp_unknown_opcode (rsp_unknown_opcode),
      .rsp_words_held     (rsp_words_held),
      .rsp_draw_mode      (rsp_draw_mode)
   );

   packet_result_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command_word   (req_command_word),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_packet_done    (rsp_packet_done),
      .rsp_command_class  (rsp_command_class),
      .rsp_unknown_opcode (rsp_unknown_opcode),
      .rsp_words_held     (rsp_words_held),
      .rsp_draw_mode      (rsp_draw_mode),
      .mismatch_count     (mismatch_count),
      .results_owed       (results_owed)
   );

   // result side backpressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // abort when no item moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // offer one command word, with random idle cycles ahead of it
   task automatic send_word(input logic [31:0] word);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid        = 1'b0;
         req_command_word = $urandom;
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_command_word = word;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // opcode word followed by random parameter words
   task automatic send_packet(input logic [7:0] opcode, input int words);
      send_word({opcode, 24'($urandom)});
      for (int k = 1; k < words; k++) begin
         send_word($urandom);
      end
   endtask

   // hold the sender until every predicted result has come back
   task automatic wait_results_in();
      req_valid = 1'b0;
      while (results_owed != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      logic [7:0] opcode;
      int         words;
      int         phase_words;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, every class, draw mode and unknown opcodes
      send_word(32'h0000_0000);
      send_word(32'hFFFF_FFFF);
      send_word({OP_DRAW_MODE, 24'hFF_3FFF});
      send_word({OP_DRAW_MODE, 24'hFF_C000});
      send_word(32'hE6FF_FFFF);
      send_packet(8'h02, 3);
      send_packet(8'h20, 4);
      send_packet(8'h40, 3);
      send_packet(8'h68, 2);
      send_packet(8'h80, 4);
      send_packet(8'hA0, 3);
      send_packet(8'hDF, 3);
      wait_results_in();

      // random packets under each idling mix, drained between mixes
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 82; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 82; end
            default: begin send_idle_pct = 21; rsp_stall_pct = 21; end
         endcase
         phase_words = 0;
         while (phase_words < PHASE_WORDS) begin
            opcode = ($urandom_range(0, 9) == 0) ? OP_DRAW_MODE : 8'($urandom);
            words  = int'(packet_length(opcode));
            // some packets cut short so the next opcode lands mid-packet
            if ($urandom_range(0, 4) == 0) begin
               words = $urandom_range(1, words);
            end
            send_packet(opcode, words);
            phase_words += words;
         end
         wait_results_in();
      end

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ gpu_command_packet_assembler_top.f @@
rtl/gcpa_pkg.sv
rtl/gcpa_decode.sv
rtl/gpu_command_packet_assembler_top.sv
rtl/gcpa_checker.sv
test/packet_result_checker.sv
test/gpu_command_packet_assembler_top_tb.sv
